[src/jsu_pkg.sv]
// Package for the JSON string unescape block: command record, codes and defaults.
// Used by every module under json_string_unescape_core; depends on nothing.
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int JSU_QUEUE_DEPTH = 4;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
    localparam logic [2:0] ERR_CTRL      = 3'd2;
    localparam logic [2:0] ERR_ESCAPE    = 3'd3;
    localparam logic [2:0] ERR_HEX       = 3'd4;
    localparam logic [2:0] ERR_SURROGATE = 3'd5;

    // Characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_STR  = 4'b0010,
        PH_ESC  = 4'b0100,
        PH_HEX  = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_END  = 2'd1,
        OP_ERR  = 2'd2,
        OP_CP   = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] value;
        logic [2:0]  err;
    } t_cmd;

endpackage

[src/jsu_front.sv]
// Front end: string/escape state machine that turns each input byte into at most one command.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);

    t_phase      r_phase,   n_phase;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [11:0] r_acc,     n_acc;
    logic [4:0]  hex_v;
    logic [15:0] cp;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b0, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            v = {1'b0, c[3:0] + 4'd9};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

    assign hex_v = hex_value(i_byte);
    assign cp    = {r_acc, hex_v[3:0]};

    always_comb begin
        n_phase     = r_phase;
        n_hex_cnt   = r_hex_cnt;
        n_acc       = r_acc;
        o_cmd_valid = 1'b0;
        o_cmd.op    = OP_BYTE;
        o_cmd.value = {8'h00, i_byte};
        o_cmd.err   = ERR_NONE;
        case (r_phase)
            PH_IDLE: begin
                if (i_byte == CH_QUOTE) begin
                    n_phase = PH_STR;
                end else begin
                    o_cmd_valid = 1'b1;
                    o_cmd.op    = OP_ERR;
                    o_cmd.err   = ERR_NO_QUOTE;
                end
            end
            PH_STR: begin
                if (i_byte == CH_QUOTE) begin
                    n_phase     = PH_IDLE;
                    o_cmd_valid = 1'b1;
                    o_cmd.op    = OP_END;
                end else if (i_byte < 8'h20) begin
                    n_phase     = PH_IDLE;
                    o_cmd_valid = 1'b1;
                    o_cmd.op    = OP_ERR;
                    o_cmd.err   = ERR_CTRL;
                end else if (i_byte == CH_BSLASH) begin
                    n_phase = PH_ESC;
                end else begin
                    o_cmd_valid = 1'b1;
                end
            end
            PH_ESC: begin
                n_phase     = PH_STR;
                o_cmd_valid = 1'b1;
                case (i_byte)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: o_cmd.value = {8'h00, i_byte};
                    8'h62: o_cmd.value = 16'h0008;
                    8'h66: o_cmd.value = 16'h000c;
                    8'h6e: o_cmd.value = 16'h000a;
                    8'h72: o_cmd.value = 16'h000d;
                    8'h74: o_cmd.value = 16'h0009;
                    CH_U: begin
                        n_phase     = PH_HEX;
                        n_hex_cnt   = 2'd0;
                        n_acc       = 12'h000;
                        o_cmd_valid = 1'b0;
                    end
                    default: begin
                        n_phase   = PH_IDLE;
                        n_hex_cnt = 2'd0;
                        n_acc     = 12'h000;
                        o_cmd.op  = OP_ERR;
                        o_cmd.err = ERR_ESCAPE;
                    end
                endcase
            end
            PH_HEX: begin
                if (hex_v[4]) begin
                    n_phase     = PH_IDLE;
                    n_hex_cnt   = 2'd0;
                    n_acc       = 12'h000;
                    o_cmd_valid = 1'b1;
                    o_cmd.op    = OP_ERR;
                    o_cmd.err   = ERR_HEX;
                end else if (r_hex_cnt != 2'd3) begin
                    n_acc     = cp[11:0];
                    n_hex_cnt = r_hex_cnt + 2'd1;
                end else begin
                    n_hex_cnt   = 2'd0;
                    n_acc       = 12'h000;
                    o_cmd_valid = 1'b1;
                    if (cp inside {[16'hd800:16'hdfff]}) begin
                        n_phase   = PH_IDLE;
                        o_cmd.op  = OP_ERR;
                        o_cmd.err = ERR_SURROGATE;
                    end else begin
                        n_phase     = PH_STR;
                        o_cmd.op    = OP_CP;
                        o_cmd.value = cp;
                    end
                end
            end
            default: begin
                n_phase   = PH_IDLE;
                n_hex_cnt = 2'd0;
                n_acc     = 12'h000;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_hex_cnt <= 2'd0;
            r_acc     <= 12'h000;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_hex_cnt <= n_hex_cnt;
            r_acc     <= n_acc;
        end
    end

endmodule

[src/jsu_queue.sv]
// Command queue between front and back ends; show-ahead register FIFO.
// Depends on jsu_pkg for the command record.
`timescale 1ns / 1ps

module jsu_queue import jsu_pkg::*; #(
    parameter int DEPTH = JSU_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/jsu_back.sv]
// Back end: expands each queued command into one to three result items (UTF-8 encode).
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    input  logic       pop,
    output logic       empty,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_error_code,
    output logic       o_last
);

    logic [1:0]  r_idx;
    logic [1:0]  item_total;
    logic [15:0] v;

    assign v     = i_cmd.value;
    assign empty = !i_cmd_valid;

    always_comb begin
        item_total = 2'd1;
        if (i_cmd.op == OP_CP) begin
            if (v <= 16'h007f) begin
                item_total = 2'd1;
            end else if (v <= 16'h07ff) begin
                item_total = 2'd2;
            end else begin
                item_total = 2'd3;
            end
        end
    end

    assign o_last = (r_idx == item_total - 2'd1);

    always_comb begin
        o_result_kind = KIND_DATA;
        o_out_byte    = 8'h00;
        o_error_code  = ERR_NONE;
        case (i_cmd.op)
            OP_BYTE: o_out_byte = v[7:0];
            OP_END:  o_result_kind = KIND_END;
            OP_ERR: begin
                o_result_kind = KIND_ERR;
                o_error_code  = i_cmd.err;
            end
            OP_CP: begin
                case (item_total)
                    2'd1: o_out_byte = v[7:0];
                    2'd2: o_out_byte = (r_idx == 2'd0) ? {3'b110, v[10:6]}
                                                       : {2'b10, v[5:0]};
                    default: begin
                        case (r_idx)
                            2'd0:    o_out_byte = {4'b1110, v[15:12]};
                            2'd1:    o_out_byte = {2'b10, v[11:6]};
                            default: o_out_byte = {2'b10, v[5:0]};
                        endcase
                    end
                endcase
            end
            default: o_result_kind = KIND_DATA;
        endcase
    end

    assign o_cmd_pop = pop && i_cmd_valid && o_last;

    // advance within a command, drop it after its last item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (pop && i_cmd_valid) begin
            r_idx <= o_last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

[src/json_string_unescape_core.sv]
// Top level of the JSON string unescape block: front end, command queue, back end.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   input   | push / full          | i_in_byte
//   result  | empty / pop          | o_result_kind, o_out_byte, o_error_code, o_last
//
// One input byte is taken per cycle while full is low; the front state machine decides
// each byte in that cycle and writes at most one command into the queue.
// A command shows on the result ports once it is at the head of the queue; the back end
// gives one result item per cycle while pop is high, three for the widest \u escape,
// which spans six bytes. full is high whenever the queue holds QUEUE_DEPTH commands; hold
// push then. Reset (i_rst_n low at a clock edge) empties the queue and returns to idle.
`timescale 1ns / 1ps

module json_string_unescape_core import jsu_pkg::*; #(
    parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_error_code,
    output logic       o_last
);

    logic take;
    logic f_cmd_valid;
    t_cmd f_cmd;
    logic q_valid;
    t_cmd q_head;
    logic q_pop;

    assign take = push && !full;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_in_byte),
        .o_cmd_valid (f_cmd_valid),
        .o_cmd       (f_cmd)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take && f_cmd_valid),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_head),
        .o_cmd_pop     (q_pop),
        .pop           (pop),
        .empty         (empty),
        .o_result_kind (o_result_kind),
        .o_out_byte    (o_out_byte),
        .o_error_code  (o_error_code),
        .o_last        (o_last)
    );

endmodule

[src/jsu_checker.sv]
// Port-level checks for json_string_unescape_core, attached by bind.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_checker import jsu_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_result_kind,
    input logic [7:0] o_out_byte,
    input logic [2:0] o_error_code,
    input logic       o_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue not empty after reset");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result_kind == KIND_ERR |->
            (o_error_code == ERR_NO_QUOTE || o_error_code == ERR_CTRL ||
             o_error_code == ERR_ESCAPE || o_error_code == ERR_HEX ||
             o_error_code == ERR_SURROGATE) && o_last)
        else $error("error item with bad code or not last");

    a_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result_kind != KIND_ERR |-> o_error_code == ERR_NONE &&
            (o_result_kind == KIND_DATA || o_result_kind == KIND_END))
        else $error("code on non-error item or bad kind");

    a_end_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result_kind == KIND_END |-> o_out_byte == 8'h00 && o_last)
        else $error("end item malformed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_byte) && $stable(o_result_kind))
        else $error("stalled item changed");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_result_kind (o_result_kind),
    .o_out_byte    (o_out_byte),
    .o_error_code  (o_error_code),
    .o_last        (o_last)
);
